// File: rtl/heat_stencil_five_point_assert.svh
// Assertion macros used by the heat_stencil_five_point RTL.
// Users must have clk_i and rst_ni in scope where the macros expand.
`ifndef HEAT_STENCIL_FIVE_POINT_ASSERT_SVH
`define HEAT_STENCIL_FIVE_POINT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSFP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HSFP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: rtl/hsfp_pkg.sv
// Shared widths, defaults and data types of the five-point heat stencil.
// No dependencies.
package hsfp_pkg;

  localparam int VALUE_W = 32;
  localparam int COEF_W  = 16;
  localparam int SIZE_W  = 11;
  localparam int DIFF_W  = VALUE_W + 2;

  localparam int MAX_ROW_POINTS_DEF = 1024;
  localparam int MAX_ROWS_DEF       = 1024;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic [COEF_W-1:0]         coef_t;

endpackage

// File: rtl/hsfp_calc.sv
// Scaled second differences plus center value, with saturation.
// Depends on hsfp_pkg. One register stage after the multipliers.
module hsfp_calc (
  input  logic            clk_i,
  input  hsfp_pkg::diff_t dxx_i,
  input  hsfp_pkg::diff_t dyy_i,
  input  hsfp_pkg::value_t u_i,
  input  hsfp_pkg::coef_t coef_x_i,
  input  hsfp_pkg::coef_t coef_y_i,
  output hsfp_pkg::value_t value_o
);
  import hsfp_pkg::*;

  localparam int PROD_W = DIFF_W + COEF_W + 1;
  localparam int SH_W   = PROD_W - COEF_W;
  localparam int SUM_W  = SH_W + 2;

  logic signed [PROD_W-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [SH_W-1:0]   sh_x, sh_y;
  logic signed [SUM_W-1:0]  sum;
  value_t                   u_q;

  assign prod_x_d = PROD_W'(dxx_i) * PROD_W'($signed({1'b0, coef_x_i}));
  assign prod_y_d = PROD_W'(dyy_i) * PROD_W'($signed({1'b0, coef_y_i}));

  always_ff @(posedge clk_i) begin
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    u_q      <= u_i;
  end

  assign sh_x = SH_W'(prod_x_q >>> COEF_W);
  assign sh_y = SH_W'(prod_y_q >>> COEF_W);
  assign sum  = SUM_W'(u_q) + SUM_W'(sh_x) + SUM_W'(sh_y);

  always_comb begin
    if (sum[SUM_W-1:VALUE_W-1] == '0 || sum[SUM_W-1:VALUE_W-1] == '1) begin
      value_o = sum[VALUE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      value_o = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      value_o = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

endmodule

// File: rtl/heat_stencil_five_point.sv
// Channel | Direction | Beat contents
// in      | sink      | grid_value_i, frame_start_i (valid/ready)
// out     | source    | new_value_o, out_column_o, out_row_o, frame_last_o (valid/ready)
// cfg     | sink      | cfg_index_i, cfg_data_i (valid/ready, always ready)
// One input beat per cycle while ready is high; results pass stage 1 and 2 registers.
// The row stores are read at acceptance and written back the next cycle; a read of
// the entry being written in that cycle takes the new data from a bypass register.
// Ready drops while four results are pending in the pipeline and output queue.
// Reset clears counters, window and queue; the row stores hold no reset value.
module heat_stencil_five_point #(
  parameter int MAX_ROW_POINTS = hsfp_pkg::MAX_ROW_POINTS_DEF,
  parameter int MAX_ROWS       = hsfp_pkg::MAX_ROWS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  hsfp_pkg::value_t                   grid_value_i,
  input  logic                               frame_start_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output hsfp_pkg::value_t                   new_value_o,
  output logic [$clog2(MAX_ROW_POINTS)-1:0]  out_column_o,
  output logic [$clog2(MAX_ROWS)-1:0]        out_row_o,
  output logic                               frame_last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  hsfp_pkg::coef_t                    cfg_data_i
);
  import hsfp_pkg::*;

  `include "heat_stencil_five_point_assert.svh"

  localparam int CW  = $clog2(MAX_ROW_POINTS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int PCW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int PRW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

  localparam logic [1:0] REG_ROW_POINTS = 2'd0;
  localparam logic [1:0] REG_ROW_TOTAL  = 2'd1;
  localparam logic [1:0] REG_COEF_X     = 2'd2;
  localparam logic [1:0] REG_COEF_Y     = 2'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Configuration registers.
  logic [SIZE_W-1:0] row_points_q, row_total_q;
  coef_t             coef_x_q, coef_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_points_q <= SIZE_W'(103);
      row_total_q  <= SIZE_W'(103);
      coef_x_q     <= COEF_W'(14746);
      coef_y_q     <= COEF_W'(14746);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROW_POINTS: row_points_q <= cfg_data_i[SIZE_W-1:0];
        REG_ROW_TOTAL:  row_total_q  <= cfg_data_i[SIZE_W-1:0];
        REG_COEF_X:     coef_x_q     <= cfg_data_i;
        REG_COEF_Y:     coef_y_q     <= cfg_data_i;
      endcase
    end
  end

  // Effective sizes.
  logic [PCW-1:0] rp_raw, rp;
  logic [PRW-1:0] rt_raw, rt;

  always_comb begin
    rp_raw = PCW'(row_points_q);
    rt_raw = PRW'(row_total_q);
    if (rp_raw < PCW'(3)) begin
      rp = PCW'(3);
    end else if (rp_raw > PCW'(MAX_ROW_POINTS)) begin
      rp = PCW'(MAX_ROW_POINTS);
    end else begin
      rp = rp_raw;
    end
    if (rt_raw < PRW'(3)) begin
      rt = PRW'(3);
    end else if (rt_raw > PRW'(MAX_ROWS)) begin
      rt = PRW'(MAX_ROWS);
    end else begin
      rt = rt_raw;
    end
  end

  // Acceptance stage: position counters and store read.
  logic [CNT_W-1:0] occ_q, occ_d;
  logic             in_fire, out_fire;
  logic [CW-1:0]    col_q, col_eff, col_d, rd_addr;
  logic [RW-1:0]    row_q, row_eff, row_d, row_c;
  logic [PCW-1:0]   col_inc;
  logic [PRW-1:0]   row_inc;
  logic             produce, last_pt;

  assign in_ready_o = occ_q < CNT_W'(FIFO_DEPTH);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    col_eff = frame_start_i ? '0 : col_q;
    row_eff = frame_start_i ? '0 : row_q;
    rd_addr = (PCW'(col_eff) >= rp) ? CW'(rp - PCW'(1)) : col_eff;
    row_c   = (PRW'(row_eff) >= rt) ? RW'(rt - PRW'(1)) : row_eff;
    produce = PCW'(col_eff) >= PCW'(2) && PCW'(col_eff) < rp &&
              PRW'(row_eff) >= PRW'(2) && PRW'(row_eff) < rt;
    last_pt = PCW'(rd_addr) == rp - PCW'(1) && PRW'(row_c) == rt - PRW'(1);
    col_inc = PCW'(col_eff) + PCW'(1);
    row_inc = PRW'(row_eff) + PRW'(1);
    if (col_inc >= rp) begin
      col_d = '0;
      row_d = (row_inc >= rt) ? '0 : RW'(row_inc);
    end else begin
      col_d = CW'(col_inc);
      row_d = row_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Row stores.
  value_t upper_mem  [MAX_ROW_POINTS];
  value_t middle_mem [MAX_ROW_POINTS];
  value_t upper_rd_q, middle_rd_q;

  // Stage 1: resolved store data, window, write-back.
  logic          s1_valid_q, s1_prod_q, s1_last_q, byp_q;
  logic [CW-1:0] s1_addr_q, s1_col_q;
  logic [RW-1:0] s1_row_q;
  value_t        s1_value_q, byp_upper_q, byp_middle_q;
  value_t        upper_here, middle_here;
  value_t        window_q [4];
  diff_t         dxx, dyy;

  assign upper_here  = byp_q ? byp_upper_q  : upper_rd_q;
  assign middle_here = byp_q ? byp_middle_q : middle_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      upper_rd_q  <= upper_mem[rd_addr];
      middle_rd_q <= middle_mem[rd_addr];
    end
    if (s1_valid_q) begin
      upper_mem[s1_addr_q]  <= middle_here;
      middle_mem[s1_addr_q] <= s1_value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      byp_q      <= in_fire && s1_valid_q && (s1_addr_q == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q    <= rd_addr;
      s1_value_q   <= grid_value_i;
      s1_prod_q    <= produce;
      s1_col_q     <= CW'(rd_addr - CW'(1));
      s1_row_q     <= RW'(row_c - RW'(1));
      s1_last_q    <= last_pt;
      byp_upper_q  <= middle_here;
      byp_middle_q <= s1_value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        window_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      window_q[3] <= window_q[1];
      window_q[0] <= upper_here;
      window_q[1] <= middle_here;
      window_q[2] <= s1_value_q;
    end
  end

  // East and west along the middle row, north and south across rows.
  assign dxx = DIFF_W'(middle_here) + DIFF_W'(window_q[3]) - (DIFF_W'(window_q[1]) <<< 1);
  assign dyy = DIFF_W'(window_q[2]) + DIFF_W'(window_q[0]) - (DIFF_W'(window_q[1]) <<< 1);

  // Stage 2: arithmetic finishes, result enters the output queue.
  logic          s2_push_q, s2_last_q;
  logic [CW-1:0] s2_col_q;
  logic [RW-1:0] s2_row_q;
  value_t        calc_value;

  hsfp_calc u_calc (
    .clk_i    (clk_i),
    .dxx_i    (dxx),
    .dyy_i    (dyy),
    .u_i      (window_q[1]),
    .coef_x_i (coef_x_q),
    .coef_y_i (coef_y_q),
    .value_o  (calc_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_push_q <= 1'b0;
    end else begin
      s2_push_q <= s1_valid_q && s1_prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_col_q  <= s1_col_q;
    s2_row_q  <= s1_row_q;
    s2_last_q <= s1_last_q;
  end

  // Output queue.
  value_t           fifo_value_q [FIFO_DEPTH];
  logic [CW-1:0]    fifo_col_q   [FIFO_DEPTH];
  logic [RW-1:0]    fifo_row_q   [FIFO_DEPTH];
  logic             fifo_last_q  [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fifo_cnt_q;

  assign out_valid_o  = fifo_cnt_q != '0;
  assign out_fire     = out_valid_o && out_ready_i;
  assign new_value_o  = fifo_value_q[rd_ptr_q];
  assign out_column_o = fifo_col_q[rd_ptr_q];
  assign out_row_o    = fifo_row_q[rd_ptr_q];
  assign frame_last_o = fifo_last_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (s2_push_q) begin
      fifo_value_q[wr_ptr_q] <= calc_value;
      fifo_col_q[wr_ptr_q]   <= s2_col_q;
      fifo_row_q[wr_ptr_q]   <= s2_row_q;
      fifo_last_q[wr_ptr_q]  <= s2_last_q;
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (in_fire && produce) begin
      occ_d = occ_d + CNT_W'(1);
    end
    if (out_fire) begin
      occ_d = occ_d - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      occ_q      <= '0;
    end else begin
      occ_q <= occ_d;
      if (s2_push_q) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (s2_push_q && !out_fire) begin
        fifo_cnt_q <= fifo_cnt_q + CNT_W'(1);
      end else if (!s2_push_q && out_fire) begin
        fifo_cnt_q <= fifo_cnt_q - CNT_W'(1);
      end
    end
  end

  `HSFP_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= CNT_W'(FIFO_DEPTH))
  `HSFP_ASSERT_IMP(a_fifo_in_occ, 1'b1, fifo_cnt_q <= occ_q)
  `HSFP_ASSERT_IMP(a_push_room, s2_push_q, fifo_cnt_q < CNT_W'(FIFO_DEPTH))
  `HSFP_ASSERT_NXT(a_bypass_hit, in_fire && s1_valid_q && (s1_addr_q == rd_addr), byp_q)

endmodule

// File: bench/heat_stencil_five_point_test.sv
// Self-checking bench for heat_stencil_five_point: streams grid frames through
// valid/ready handshakes and checks every updated interior point against a local model.
// Depends on hsfp_pkg and the heat_stencil_five_point RTL.
module heat_stencil_five_point_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hsfp_pkg::*;

  localparam int MAX_COLS = MAX_ROW_POINTS_DEF;
  localparam int MAX_ROWS = MAX_ROWS_DEF;
  localparam int RANDOM_POINTS = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam value_t VALUE_HIGH = 32'sh7FFFFFFF;
  localparam value_t VALUE_LOW = 32'sh80000000;
  localparam longint SUM_HIGH = 64'sd2147483647;
  localparam longint SUM_LOW = -64'sd2147483648;

  typedef enum logic [1:0] {
    REG_ROW_POINTS = 2'd0,
    REG_ROW_TOTAL  = 2'd1,
    REG_COEF_X     = 2'd2,
    REG_COEF_Y     = 2'd3
  } reg_index_e;

  typedef struct packed {
    value_t     value;
    logic [9:0] column;
    logic [9:0] row;
    logic       last;
  } grid_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  value_t     grid_value_i = '0;
  logic       frame_start_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  value_t     new_value_o;
  logic [9:0] out_column_o;
  logic [9:0] out_row_o;
  logic       frame_last_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = REG_ROW_POINTS;
  coef_t      cfg_data_i = '0;

  logic [10:0] row_points_q;
  logic [10:0] row_total_q;
  coef_t       coef_x_q;
  coef_t       coef_y_q;
  value_t      upper_rows [MAX_COLS];
  value_t      middle_rows [MAX_COLS];
  value_t      window_q [4];
  int unsigned col_count_q;
  int unsigned row_count_q;

  grid_result_t expected_points [$];
  grid_result_t oldest_point;
  int error_count = 0;
  int inputs_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  bit idle_off = 1'b0;

  heat_stencil_five_point DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .grid_value_i  (grid_value_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .new_value_o   (new_value_o),
    .out_column_o  (out_column_o),
    .out_row_o     (out_row_o),
    .frame_last_o  (frame_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned eff_size(input logic [10:0] raw, input int unsigned hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic int draw_wait();
    return idle_off ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic coef_t draw_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'hFFFF;
      2: return coef_t'($urandom_range(0, 16384));
      default: return coef_t'($urandom);
    endcase
  endfunction

  function automatic value_t draw_value(input int mode);
    case (mode)
      0: return value_t'($urandom);
      1: return value_t'($signed($urandom_range(0, 33554431)) - 16777216);
      default: begin
        case ($urandom_range(0, 4))
          0: return VALUE_HIGH;
          1: return VALUE_LOW;
          2: return '0;
          3: return value_t'(-1);
          default: return value_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Advances the local copy of the stencil by one accepted grid point.
  function automatic void stencil_update(input value_t point, input logic start);
    int unsigned rp;
    int unsigned rt;
    int unsigned c;
    int unsigned r;
    value_t upper_here;
    value_t middle_here;
    longint u_val;
    longint dxx;
    longint dyy;
    longint total;
    grid_result_t upd;
    rp = eff_size(row_points_q, MAX_COLS);
    rt = eff_size(row_total_q, MAX_ROWS);
    if (start) begin
      col_count_q = 0;
      row_count_q = 0;
    end
    c = (col_count_q >= rp) ? rp - 1 : col_count_q;
    r = (row_count_q >= rt) ? rt - 1 : row_count_q;
    upper_here = upper_rows[c];
    middle_here = middle_rows[c];
    if (c >= 2 && r >= 2 && col_count_q < rp && row_count_q < rt) begin
      u_val = longint'(window_q[1]);
      dxx = longint'(middle_here) - 2 * u_val + longint'(window_q[3]);
      dyy = longint'(window_q[2]) - 2 * u_val + longint'(window_q[0]);
      total = u_val + ((dxx * longint'(coef_x_q)) >>> 16)
                    + ((dyy * longint'(coef_y_q)) >>> 16);
      if (total > SUM_HIGH) total = SUM_HIGH;
      if (total < SUM_LOW) total = SUM_LOW;
      upd.value = value_t'(total);
      upd.column = 10'(c - 1);
      upd.row = 10'(r - 1);
      upd.last = (c == rp - 1) && (r == rt - 1);
      expected_points.push_back(upd);
    end
    window_q[3] = window_q[1];
    window_q[0] = upper_here;
    window_q[1] = middle_here;
    window_q[2] = point;
    upper_rows[c] = middle_here;
    middle_rows[c] = point;
    if (col_count_q + 1 >= rp) begin
      col_count_q = 0;
      row_count_q = (row_count_q + 1 >= rt) ? 0 : row_count_q + 1;
    end else begin
      col_count_q = col_count_q + 1;
    end
  endfunction

  task automatic send_point(input value_t point, input logic start);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    grid_value_i <= point;
    frame_start_i <= start;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    stencil_update(point, start);
    inputs_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after its last write.
  task automatic write_reg(input reg_index_e idx, input coef_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_ROW_POINTS: row_points_q = data[10:0];
      REG_ROW_TOTAL:  row_total_q = data[10:0];
      REG_COEF_X:     coef_x_q = data;
      REG_COEF_Y:     coef_y_q = data;
      default: ;
    endcase
  endtask

  task automatic configure(input coef_t points, input coef_t rows, input coef_t cx,
                           input coef_t cy);
    drain_pipeline();
    write_reg(REG_ROW_POINTS, points);
    write_reg(REG_ROW_TOTAL, rows);
    write_reg(REG_COEF_X, cx);
    write_reg(REG_COEF_Y, cy);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic test_saturation();
    configure(16'd3, 16'd3, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 9; i++) send_point((i == 4) ? VALUE_LOW : VALUE_HIGH, i == 0);
    // The second frame follows the first without a frame start.
    for (int i = 0; i < 9; i++) send_point((i == 4) ? VALUE_HIGH : VALUE_LOW, 1'b0);
  endtask

  task automatic test_clamped_sizes();
    // Both sizes fall below the minimum; a small negative term must round down.
    configure(16'hF800, 16'd2, 16'd1, 16'd0);
    for (int i = 0; i < 9; i++) send_point((i == 5) ? value_t'(-1) : value_t'(0), i == 0);
  endtask

  task automatic test_size_extremes();
    // One full-width row, then a narrower width shows where the counters wrapped.
    configure(16'd2047, 16'd0, draw_coef(), draw_coef());
    for (int i = 0; i < MAX_COLS + 6; i++) send_point(draw_value(1), i == 0);
    drain_pipeline();
    write_reg(REG_ROW_POINTS, 16'd8);
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < 10; i++) send_point(draw_value(1), 1'b0);
    idle_off = 1'b1;
    configure(16'd3, 16'd1024, draw_coef(), draw_coef());
    for (int i = 0; i < 90; i++) send_point(draw_value(1), i == 0);
    idle_off = 1'b0;
  endtask

  task automatic test_resize_midframe();
    configure(16'd10, 16'd5, draw_coef(), draw_coef());
    for (int i = 0; i < 34; i++) send_point(draw_value(1), i == 0);
    drain_pipeline();
    write_reg(REG_ROW_POINTS, 16'd6);
    write_reg(REG_ROW_TOTAL, 16'd9);
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < 120; i++) send_point(draw_value(1), 1'b0);
    configure(16'd12, 16'd8, draw_coef(), draw_coef());
    for (int i = 0; i < 81; i++) send_point(draw_value(0), i == 0);
    drain_pipeline();
    write_reg(REG_ROW_POINTS, 16'd5);
    write_reg(REG_ROW_TOTAL, 16'd4);
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < 60; i++) send_point(draw_value(1), 1'b0);
  endtask

  task automatic test_random_frames();
    int first_point;
    int rp;
    int rt;
    int frames;
    int points;
    int mode;
    logic lead;
    first_point = inputs_sent;
    while (inputs_sent - first_point < RANDOM_POINTS) begin
      rp = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(3, 12);
      rt = $urandom_range(3, 9);
      configure(coef_t'(rp), coef_t'(rt), draw_coef(), draw_coef());
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        idle_off = ($urandom_range(0, 4) == 0);
        mode = $urandom_range(0, 2);
        points = rp * rt;
        if ($urandom_range(0, 7) == 0) points = $urandom_range(1, points - 1);
        lead = (f == 0) || ($urandom_range(0, 1) == 1);
        for (int i = 0; i < points; i++) begin
          send_point(draw_value(mode), (i == 0 && lead) || ($urandom_range(0, 299) == 0));
        end
      end
    end
    idle_off = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_points.size() == 0) begin
        $display("%t: result beat with nothing expected, expected none, actual %h",
                 $time, new_value_o);
        error_count++;
      end else begin
        oldest_point = expected_points.pop_front();
        compare_field("new_value", oldest_point.value, new_value_o);
        compare_field("out_column", oldest_point.column, out_column_o);
        compare_field("out_row", oldest_point.row, out_row_o);
        compare_field("frame_last", oldest_point.last, frame_last_o);
      end
    end
  end

  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    row_points_q = 11'd103;
    row_total_q = 11'd103;
    coef_x_q = 16'd14746;
    coef_y_q = 16'd14746;
    for (int i = 0; i < MAX_COLS; i++) begin
      upper_rows[i] = '0;
      middle_rows[i] = '0;
    end
    for (int i = 0; i < 4; i++) window_q[i] = '0;
    col_count_q = 0;
    row_count_q = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_saturation();
    test_clamped_sizes();
    test_size_extremes();
    test_resize_midframe();
    test_random_frames();
    drain_pipeline();
    $display("Sent %0d grid beats under %0d register settings and checked %0d updated points,",
             inputs_sent, settings_used, results_seen);
    $display("covering saturation, clamped sizes, full-width rows and mid-frame resizing.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/hsfp_pkg.sv
rtl/hsfp_calc.sv
rtl/heat_stencil_five_point.sv
bench/heat_stencil_five_point_test.sv
